### src/rgfp_pkg.sv
// Shared types and constants for the render gate and frame pacer.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rgfp_pkg;

   localparam int FRAC_W      = 17;
   localparam int MS_W        = 16;
   localparam int FPS_W       = 8;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;

   // Frame interval divider: 1000 / fps, one quotient bit per step.
   localparam int DIV_BITS    = 10;
   localparam int DIV_CNT_W   = $clog2(DIV_BITS + 1);
   localparam logic [DIV_BITS-1:0] FRAME_DIVIDEND = DIV_BITS'(1000);

   // Configuration reset values.
   localparam logic [FRAC_W-1:0] STOP_BELOW_RESET   = FRAC_W'(3277);
   localparam logic [FRAC_W-1:0] RESUME_ABOVE_RESET = FRAC_W'(6554);
   localparam logic [MS_W-1:0]   POLL_RESET         = MS_W'(1000);
   localparam logic [MS_W-1:0]   STOP_DELAY_RESET   = MS_W'(400);

   typedef enum logic [OP_W-1:0] {
      OP_EVAL = 2'd0,
      OP_TICK = 2'd1,
      OP_NEW  = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STOP_BELOW   = 3'd0,
      CSR_RESUME_ABOVE = 3'd1,
      CSR_POLL         = 3'd2,
      CSR_STOP_DELAY   = 3'd3,
      CSR_FORCE_ON     = 3'd4,
      CSR_COV_SUPP     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EXEC,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic exec;
      logic sum;
   } cmd_type;

   typedef struct packed {
      logic in_tick;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

### src/rgfp_ctrl.sv
// Sequencing state machine of the render gate and frame pacer.
// Depends on rgfp_pkg; drives the datapath through cmd_type and reads status_type.
`timescale 1ns / 1ps

module rgfp_ctrl
   import rgfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.in_tick ? ST_DIV : ST_EXEC;
            end
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_SUM: begin
            cmd.sum = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/rgfp_dp.sv
// Datapath: item registers, gating state, frame interval divider and result register.
// Depends on rgfp_pkg; commanded by rgfp_ctrl.
`timescale 1ns / 1ps

module rgfp_dp
   import rgfp_pkg::*;
#(
   parameter int TIME_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [OP_W-1:0]       req_op,
   input  logic [TIME_BITS-1:0]  req_now_ms,
   input  logic                  req_system_blocked,
   input  logic [FRAC_W-1:0]     req_visible_fraction,
   input  logic                  req_source_present,
   input  logic                  req_surface_present,
   input  logic                  req_surface_ready,
   input  logic                  req_frame_requested,
   input  logic                  req_context_ok,
   input  logic [FPS_W-1:0]      req_frames_per_second,
   input  logic                  req_render_ok,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_start_source,
   output logic                  rsp_stop_source,
   output logic                  rsp_coverage_changed,
   output logic                  rsp_render_issued,
   output logic                  rsp_frame_presented,
   output logic                  rsp_source_running,
   output logic [TIME_BITS-1:0]  rsp_next_deadline_ms
);

   // Saturating time sum.
   function automatic logic [TIME_BITS-1:0] tadd(input logic [TIME_BITS-1:0] a,
                                                 input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction

   function automatic logic [TIME_BITS-1:0] earliest(input logic [TIME_BITS-1:0] d,
                                                     input logic [TIME_BITS-1:0] t);
      if (d == '0) begin
         return t;
      end
      return (t < d) ? t : d;
   endfunction

   // Configuration registers.
   logic [FRAC_W-1:0] stop_below_ff, stop_below_in;
   logic [FRAC_W-1:0] resume_above_ff, resume_above_in;
   logic [MS_W-1:0]   poll_ff, poll_in;
   logic [MS_W-1:0]   stop_delay_ff, stop_delay_in;
   logic              force_on_ff, force_on_in;
   logic              cov_supp_ff, cov_supp_in;

   // Gating and pacing state.
   logic                 covered_ff, covered_in;
   logic                 active_ff, active_in;
   logic [TIME_BITS-1:0] nft_ff, nft_in;
   logic [TIME_BITS-1:0] npt_ff, npt_in;
   logic [TIME_BITS-1:0] sat_ff, sat_in;

   // Captured item.
   logic [OP_W-1:0]      op_ff, op_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 blocked_ff, blocked_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic                 src_ff, src_in;
   logic                 surf_ff, surf_in;
   logic                 ready_ff, ready_in;
   logic                 requested_ff, requested_in;
   logic                 ctx_ff, ctx_in;
   logic                 rok_ff, rok_in;

   // Divider.
   logic [DIV_BITS-1:0]  dvd_ff, dvd_in;
   logic [DIV_BITS-1:0]  quot_ff, quot_in;
   logic [FPS_W-1:0]     rem_ff, rem_in;
   logic [FPS_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Per-item pulses.
   logic start_ff, start_in;
   logic stop_ff, stop_in;
   logic cchg_ff, cchg_in;
   logic issued_ff, issued_in;
   logic presented_ff, presented_in;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   logic                 out_start_ff, out_start_in;
   logic                 out_stop_ff, out_stop_in;
   logic                 out_cchg_ff, out_cchg_in;
   logic                 out_issued_ff, out_issued_in;
   logic                 out_presented_ff, out_presented_in;
   logic                 out_running_ff, out_running_in;
   logic [TIME_BITS-1:0] out_deadline_ff, out_deadline_in;

   // Combinational helpers.
   logic                 sample_c;
   logic                 latch_c;
   logic                 should_c;
   logic                 tick_ok_c;
   logic [TIME_BITS-1:0] poll_sum_c;
   logic [TIME_BITS-1:0] stop_sum_c;
   logic [TIME_BITS-1:0] tick_a_c;
   logic [TIME_BITS-1:0] tick_b_c;
   logic [TIME_BITS-1:0] deadline_c;
   logic [MS_W-1:0]      delay_c;
   logic [FPS_W:0]       trial_c;
   logic                 qbit_c;

   assign status.in_tick  = (req_op == OP_TICK);
   assign status.div_last = (div_cnt_ff == DIV_CNT_W'(1));
   assign status.out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      delay_c    = (stop_delay_ff == '0) ? MS_W'(1) : stop_delay_ff;
      sample_c   = !blocked_ff && (now_ff >= npt_ff);
      poll_sum_c = tadd(now_ff, TIME_BITS'(poll_ff));
      stop_sum_c = tadd(now_ff, TIME_BITS'(delay_c));
      latch_c    = covered_ff;
      if (sample_c && cov_supp_ff) begin
         latch_c = covered_ff ? !(frac_ff >= resume_above_ff) : (frac_ff < stop_below_ff);
      end
      should_c   = force_on_ff || (!blocked_ff && !latch_c);
      tick_ok_c  = src_ff && surf_ff && active_ff && ready_ff && (now_ff >= nft_ff)
                   && requested_ff && ctx_ff;
      tick_a_c   = tadd(now_ff, TIME_BITS'(1));
      tick_b_c   = tadd(nft_ff, TIME_BITS'(quot_ff));
      deadline_c = npt_ff;
      if (src_ff && active_ff) begin
         deadline_c = earliest(deadline_c, nft_ff);
      end
      if (sat_ff != '0) begin
         deadline_c = earliest(deadline_c, sat_ff);
      end
      trial_c = {rem_ff, dvd_ff[DIV_BITS-1]};
      qbit_c  = (trial_c >= {1'b0, divisor_ff});
   end

   always_comb begin
      stop_below_in   = stop_below_ff;
      resume_above_in = resume_above_ff;
      poll_in         = poll_ff;
      stop_delay_in   = stop_delay_ff;
      force_on_in     = force_on_ff;
      cov_supp_in     = cov_supp_ff;
      covered_in      = covered_ff;
      active_in       = active_ff;
      nft_in          = nft_ff;
      npt_in          = npt_ff;
      sat_in          = sat_ff;
      op_in           = op_ff;
      now_in          = now_ff;
      blocked_in      = blocked_ff;
      frac_in         = frac_ff;
      src_in          = src_ff;
      surf_in         = surf_ff;
      ready_in        = ready_ff;
      requested_in    = requested_ff;
      ctx_in          = ctx_ff;
      rok_in          = rok_ff;
      dvd_in          = dvd_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      divisor_in      = divisor_ff;
      div_cnt_in      = div_cnt_ff;
      start_in        = start_ff;
      stop_in         = stop_ff;
      cchg_in         = cchg_ff;
      issued_in       = issued_ff;
      presented_in    = presented_ff;
      out_start_in     = out_start_ff;
      out_stop_in      = out_stop_ff;
      out_cchg_in      = out_cchg_ff;
      out_issued_in    = out_issued_ff;
      out_presented_in = out_presented_ff;
      out_running_in   = out_running_ff;
      out_deadline_in  = out_deadline_ff;
      out_valid_in     = out_valid_ff && rsp_stall;

      if (csr_valid) begin
         case (csr_index)
            CSR_STOP_BELOW:   stop_below_in   = csr_wdata;
            CSR_RESUME_ABOVE: resume_above_in = csr_wdata;
            CSR_POLL:         poll_in         = csr_wdata[MS_W-1:0];
            CSR_STOP_DELAY:   stop_delay_in   = csr_wdata[MS_W-1:0];
            CSR_FORCE_ON:     force_on_in     = csr_wdata[0];
            CSR_COV_SUPP:     cov_supp_in     = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         op_in        = req_op;
         now_in       = req_now_ms;
         blocked_in   = req_system_blocked;
         frac_in      = req_visible_fraction;
         src_in       = req_source_present;
         surf_in      = req_surface_present;
         ready_in     = req_surface_ready;
         requested_in = req_frame_requested;
         ctx_in       = req_context_ok;
         rok_in       = req_render_ok;
         dvd_in       = FRAME_DIVIDEND;
         quot_in      = '0;
         rem_in       = '0;
         divisor_in   = (req_frames_per_second == '0) ? FPS_W'(1) : req_frames_per_second;
         div_cnt_in   = DIV_CNT_W'(DIV_BITS);
      end

      if (cmd.div_step) begin
         rem_in     = qbit_c ? FPS_W'(trial_c - {1'b0, divisor_ff}) : trial_c[FPS_W-1:0];
         quot_in    = {quot_ff[DIV_BITS-2:0], qbit_c};
         dvd_in     = {dvd_ff[DIV_BITS-2:0], 1'b0};
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end

      if (cmd.exec) begin
         start_in     = 1'b0;
         stop_in      = 1'b0;
         cchg_in      = 1'b0;
         issued_in    = 1'b0;
         presented_in = 1'b0;
         case (op_ff)
            OP_EVAL: begin
               if (src_ff && surf_ff) begin
                  if (sample_c) begin
                     npt_in = poll_sum_c;
                  end
                  covered_in = latch_c;
                  cchg_in    = (latch_c != covered_ff);
                  if (should_c) begin
                     sat_in = '0;
                     if (!active_ff) begin
                        active_in = 1'b1;
                        start_in  = 1'b1;
                        nft_in    = now_ff;
                     end
                  end else if (active_ff) begin
                     if (sat_ff == '0) begin
                        sat_in = stop_sum_c;
                     end else if (now_ff >= sat_ff) begin
                        // The grace period ran out while gating still says off.
                        sat_in    = '0;
                        active_in = 1'b0;
                        stop_in   = 1'b1;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (tick_ok_c) begin
                  nft_in       = (tick_a_c > tick_b_c) ? tick_a_c : tick_b_c;
                  issued_in    = 1'b1;
                  presented_in = rok_ff;
               end
            end
            OP_NEW: begin
               stop_in   = active_ff;
               active_in = 1'b0;
               sat_in    = '0;
               nft_in    = '0;
               npt_in    = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.sum) begin
         out_valid_in     = 1'b1;
         out_start_in     = start_ff;
         out_stop_in      = stop_ff;
         out_cchg_in      = cchg_ff;
         out_issued_in    = issued_ff;
         out_presented_in = presented_ff;
         out_running_in   = src_ff && active_ff;
         out_deadline_in  = deadline_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_below_ff   <= STOP_BELOW_RESET;
         resume_above_ff <= RESUME_ABOVE_RESET;
         poll_ff         <= POLL_RESET;
         stop_delay_ff   <= STOP_DELAY_RESET;
         force_on_ff     <= 1'b0;
         cov_supp_ff     <= 1'b1;
         covered_ff      <= 1'b0;
         active_ff       <= 1'b0;
         nft_ff          <= '0;
         npt_ff          <= '0;
         sat_ff          <= '0;
         div_cnt_ff      <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         stop_below_ff   <= stop_below_in;
         resume_above_ff <= resume_above_in;
         poll_ff         <= poll_in;
         stop_delay_ff   <= stop_delay_in;
         force_on_ff     <= force_on_in;
         cov_supp_ff     <= cov_supp_in;
         covered_ff      <= covered_in;
         active_ff       <= active_in;
         nft_ff          <= nft_in;
         npt_ff          <= npt_in;
         sat_ff          <= sat_in;
         div_cnt_ff      <= div_cnt_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      now_ff           <= now_in;
      blocked_ff       <= blocked_in;
      frac_ff          <= frac_in;
      src_ff           <= src_in;
      surf_ff          <= surf_in;
      ready_ff         <= ready_in;
      requested_ff     <= requested_in;
      ctx_ff           <= ctx_in;
      rok_ff           <= rok_in;
      dvd_ff           <= dvd_in;
      quot_ff          <= quot_in;
      rem_ff           <= rem_in;
      divisor_ff       <= divisor_in;
      start_ff         <= start_in;
      stop_ff          <= stop_in;
      cchg_ff          <= cchg_in;
      issued_ff        <= issued_in;
      presented_ff     <= presented_in;
      out_start_ff     <= out_start_in;
      out_stop_ff      <= out_stop_in;
      out_cchg_ff      <= out_cchg_in;
      out_issued_ff    <= out_issued_in;
      out_presented_ff <= out_presented_in;
      out_running_ff   <= out_running_in;
      out_deadline_ff  <= out_deadline_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_start_source     = out_start_ff;
   assign rsp_stop_source      = out_stop_ff;
   assign rsp_coverage_changed = out_cchg_ff;
   assign rsp_render_issued    = out_issued_ff;
   assign rsp_frame_presented  = out_presented_ff;
   assign rsp_source_running   = out_running_ff;
   assign rsp_next_deadline_ms = out_deadline_ff;

endmodule

### src/render_gate_and_frame_pacer.sv
// Render gate and frame pacer: switches a frame source on and off and paces its frames.
// Input channel (req_*): one transfer per item; req_op selects evaluate, frame tick or
// new source, and the remaining fields describe the current time and system state.
// Result channel (rsp_*): exactly one transfer per accepted item, in order, carrying the
// start/stop pulses, coverage change, frame issue flags, running flag and next deadline.
// Configuration channel (csr_*): a register index and write data, taken whenever
// csr_valid is high (csr_ready is always high); write only while the block is idle.
// Timing: an item is captured on transfer; a frame tick then runs a 10-step restoring
// divider for the 1000/fps frame interval; then the gating state is updated and the
// result is formed. The block works on one item at a time: a new item is taken only
// after the result of the last one has moved to the output register.
// The result sits in an output register; the next item is taken while it waits there.
// A stalled result holds its value; if the receiver keeps stalling, the following item
// waits in the final state until the output register frees.
// Reset (synchronous, active high) clears the gating state, the deadlines and the
// pending result, and restores every configuration register to its reset value.
`timescale 1ns / 1ps

module render_gate_and_frame_pacer
   import rgfp_pkg::*;
#(
   parameter int TIME_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration writes.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // Input items.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_op,
   input  logic [TIME_BITS-1:0]  req_now_ms,
   input  logic                  req_system_blocked,
   input  logic [FRAC_W-1:0]     req_visible_fraction,
   input  logic                  req_source_present,
   input  logic                  req_surface_present,
   input  logic                  req_surface_ready,
   input  logic                  req_frame_requested,
   input  logic                  req_context_ok,
   input  logic [FPS_W-1:0]      req_frames_per_second,
   input  logic                  req_render_ok,
   // Result items.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_start_source,
   output logic                  rsp_stop_source,
   output logic                  rsp_coverage_changed,
   output logic                  rsp_render_issued,
   output logic                  rsp_frame_presented,
   output logic                  rsp_source_running,
   output logic [TIME_BITS-1:0]  rsp_next_deadline_ms
);

   cmd_type    cmd;
   status_type status;

   // Registers take a write in any cycle; the user must keep writes to idle periods, as the block does not enforce it.
   assign csr_ready = 1'b1;

   // The controller sequences capture, division, state update and result forming.
   rgfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds configuration, gating state, the divider and the result register.
   rgfp_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_op                (req_op),
      .req_now_ms            (req_now_ms),
      .req_system_blocked    (req_system_blocked),
      .req_visible_fraction  (req_visible_fraction),
      .req_source_present    (req_source_present),
      .req_surface_present   (req_surface_present),
      .req_surface_ready     (req_surface_ready),
      .req_frame_requested   (req_frame_requested),
      .req_context_ok        (req_context_ok),
      .req_frames_per_second (req_frames_per_second),
      .req_render_ok         (req_render_ok),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_start_source      (rsp_start_source),
      .rsp_stop_source       (rsp_stop_source),
      .rsp_coverage_changed  (rsp_coverage_changed),
      .rsp_render_issued     (rsp_render_issued),
      .rsp_frame_presented   (rsp_frame_presented),
      .rsp_source_running    (rsp_source_running),
      .rsp_next_deadline_ms  (rsp_next_deadline_ms)
   );

`ifndef SYNTHESIS
   // Once an item is taken the block is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while the previous item was still in work");

   // A single step never both starts and stops the source.
   a_start_stop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_start_source && rsp_stop_source))
      else $error("start and stop pulses in the same result");

   // A presented frame is always an issued frame.
   a_present_needs_issue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_presented) |-> rsp_render_issued)
      else $error("frame presented without a render being issued");

   // Starting the source leaves it running in the same result.
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_start_source) |-> rsp_source_running)
      else $error("source started but not reported running");
`endif

endmodule

### sim/render_gate_and_frame_pacer_tb.sv
// Self-checking testbench for the render gate and frame pacer.
// Depends on rgfp_pkg and render_gate_and_frame_pacer; predicts every result internally.
`timescale 1ns / 1ps

module render_gate_and_frame_pacer_tb;
   import rgfp_pkg::*;

   localparam int TIME_BITS       = 48;
   localparam int FRAME_PERIOD_MS = 1000;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int TAIL_CYCLES     = 40;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [OP_W-1:0]       OP_UNUSED    = 2'd3;
   localparam logic [CSR_IDX_W-1:0]  CSR_UNMAPPED = 3'd7;
   localparam logic [FRAC_W-1:0]     FRAC_ONE     = FRAC_W'(65536);
   localparam logic [FRAC_W-1:0]     FRAC_MAX     = '1;
   localparam logic [TIME_BITS-1:0]  TIME_MAX     = '1;

   // One input item, as presented on the req_ ports.
   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [TIME_BITS-1:0] now_ms;
      logic                 blocked;
      logic [FRAC_W-1:0]    fraction;
      logic                 source_present;
      logic                 surface_present;
      logic                 surface_ready;
      logic                 frame_requested;
      logic                 context_ok;
      logic [FPS_W-1:0]     fps;
      logic                 render_ok;
   } gate_item_type;

   // One result item, as presented on the rsp_ ports.
   typedef struct packed {
      logic                 start_source;
      logic                 stop_source;
      logic                 coverage_changed;
      logic                 render_issued;
      logic                 frame_presented;
      logic                 source_running;
      logic [TIME_BITS-1:0] next_deadline_ms;
   } gate_result_type;

   // Clock and reset. Every block input starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_op = '0;
   logic [TIME_BITS-1:0]  req_now_ms = '0;
   logic                  req_system_blocked = 1'b0;
   logic [FRAC_W-1:0]     req_visible_fraction = '0;
   logic                  req_source_present = 1'b0;
   logic                  req_surface_present = 1'b0;
   logic                  req_surface_ready = 1'b0;
   logic                  req_frame_requested = 1'b0;
   logic                  req_context_ok = 1'b0;
   logic [FPS_W-1:0]      req_frames_per_second = '0;
   logic                  req_render_ok = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_start_source;
   logic                  rsp_stop_source;
   logic                  rsp_coverage_changed;
   logic                  rsp_render_issued;
   logic                  rsp_frame_presented;
   logic                  rsp_source_running;
   logic [TIME_BITS-1:0]  rsp_next_deadline_ms;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   render_gate_and_frame_pacer #(
      .TIME_BITS(TIME_BITS)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_now_ms            (req_now_ms),
      .req_system_blocked    (req_system_blocked),
      .req_visible_fraction  (req_visible_fraction),
      .req_source_present    (req_source_present),
      .req_surface_present   (req_surface_present),
      .req_surface_ready     (req_surface_ready),
      .req_frame_requested   (req_frame_requested),
      .req_context_ok        (req_context_ok),
      .req_frames_per_second (req_frames_per_second),
      .req_render_ok         (req_render_ok),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_start_source      (rsp_start_source),
      .rsp_stop_source       (rsp_stop_source),
      .rsp_coverage_changed  (rsp_coverage_changed),
      .rsp_render_issued     (rsp_render_issued),
      .rsp_frame_presented   (rsp_frame_presented),
      .rsp_source_running    (rsp_source_running),
      .rsp_next_deadline_ms  (rsp_next_deadline_ms)
   );

   // ------------------------------------------------------------------
   // Predictor state: the gating latch, the deadlines and a private copy
   // of the register file. Everything starts at the block's reset values.
   // ------------------------------------------------------------------
   logic [FRAC_W-1:0]    cfg_stop_below    = STOP_BELOW_RESET;
   logic [FRAC_W-1:0]    cfg_resume_above  = RESUME_ABOVE_RESET;
   logic [MS_W-1:0]      cfg_poll_ms       = POLL_RESET;
   logic [MS_W-1:0]      cfg_stop_delay_ms = STOP_DELAY_RESET;
   logic                 cfg_force_on      = 1'b0;
   logic                 cfg_cov_supported = 1'b1;

   logic                 gate_covered = 1'b0;
   logic                 gate_active  = 1'b0;
   logic [TIME_BITS-1:0] frame_due_ms = '0;
   logic [TIME_BITS-1:0] poll_due_ms  = '0;
   logic [TIME_BITS-1:0] stop_due_ms  = '0;

   gate_result_type pending_results[$];
   int unsigned     fault_count  = 0;
   int unsigned     results_seen = 0;
   int unsigned     cycle_count  = 0;

   // Stimulus controls. The random traffic re-picks the idling flags in
   // stretches, so that both busy and quiet stretches occur.
   logic                 send_idling     = 1'b1;
   logic                 stall_enabled   = 1'b1;
   logic                 idling_allowed  = 1'b1;
   int unsigned          stall_left      = 0;
   logic [TIME_BITS-1:0] wall_ms         = '0;

   // Time sums saturate at the largest representable time.
   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

   // Earliest of two deadlines, where zero stands for nothing pending.
   function automatic logic [TIME_BITS-1:0] sooner(input logic [TIME_BITS-1:0] held,
                                                   input logic [TIME_BITS-1:0] cand);
      if (held == '0) return cand;
      return (cand < held) ? cand : held;
   endfunction

   // Applies one item to the predictor state and returns the result the
   // block has to produce for it.
   function automatic gate_result_type predict_step(input gate_item_type it);
      gate_result_type      res;
      logic                 present;
      logic                 allow;
      logic                 was_covered;
      logic [FPS_W-1:0]     rate;
      logic [TIME_BITS-1:0] grace_ms;
      logic [TIME_BITS-1:0] after_now;
      logic [TIME_BITS-1:0] after_due;
      logic [TIME_BITS-1:0] soonest;
      res = '0;
      present = it.source_present && it.surface_present;
      case (it.op)
         OP_EVAL: begin
            if (present) begin
               // The visibility sample is taken only when unblocked and the poll is due.
               if (!it.blocked && it.now_ms >= poll_due_ms) begin
                  poll_due_ms = sat_add(it.now_ms, TIME_BITS'(cfg_poll_ms));
                  if (cfg_cov_supported) begin
                     was_covered = gate_covered;
                     if (gate_covered) begin
                        if (it.fraction >= cfg_resume_above) gate_covered = 1'b0;
                     end else if (it.fraction < cfg_stop_below) begin
                        gate_covered = 1'b1;
                     end
                     res.coverage_changed = (gate_covered != was_covered);
                  end
               end
               allow = cfg_force_on || (!it.blocked && !gate_covered);
               if (allow) begin
                  stop_due_ms = '0;
                  if (!gate_active) begin
                     gate_active        = 1'b1;
                     res.start_source   = 1'b1;
                     frame_due_ms       = it.now_ms;
                  end
               end else if (gate_active) begin
                  // Stopping waits out a grace delay, then re-checks the cause.
                  if (stop_due_ms == '0) begin
                     grace_ms = (cfg_stop_delay_ms == '0) ? TIME_BITS'(1)
                                                          : TIME_BITS'(cfg_stop_delay_ms);
                     stop_due_ms = sat_add(it.now_ms, grace_ms);
                  end else if (it.now_ms >= stop_due_ms) begin
                     stop_due_ms = '0;
                     if ((it.blocked || gate_covered) && !cfg_force_on) begin
                        gate_active     = 1'b0;
                        res.stop_source = 1'b1;
                     end
                  end
               end
            end
         end
         OP_TICK: begin
            if (present && gate_active && it.surface_ready && it.now_ms >= frame_due_ms &&
                it.frame_requested && it.context_ok) begin
               rate      = (it.fps == '0) ? FPS_W'(1) : it.fps;
               after_now = sat_add(it.now_ms, TIME_BITS'(1));
               after_due = sat_add(frame_due_ms, TIME_BITS'(FRAME_PERIOD_MS / int'(rate)));
               frame_due_ms        = (after_now > after_due) ? after_now : after_due;
               res.render_issued   = 1'b1;
               res.frame_presented = it.render_ok;
            end
         end
         OP_NEW: begin
            res.stop_source = gate_active;
            gate_active     = 1'b0;
            stop_due_ms     = '0;
            frame_due_ms    = '0;
            poll_due_ms     = '0;
         end
         default: begin
         end
      endcase
      soonest = poll_due_ms;
      if (it.source_present && gate_active) soonest = sooner(soonest, frame_due_ms);
      if (stop_due_ms != '0) soonest = sooner(soonest, stop_due_ms);
      res.source_running   = it.source_present && gate_active;
      res.next_deadline_ms = soonest;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Monitor. All three channels are sampled at the rising edge in one
   // process: register writes update the private register copy, accepted
   // items are predicted in order, and accepted results are compared
   // against the oldest prediction still waiting.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      gate_item_type   taken;
      gate_result_type seen;
      gate_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready === 1'b1) begin
            case (csr_index)
               CSR_STOP_BELOW:   cfg_stop_below    = csr_wdata[FRAC_W-1:0];
               CSR_RESUME_ABOVE: cfg_resume_above  = csr_wdata[FRAC_W-1:0];
               CSR_POLL:         cfg_poll_ms       = csr_wdata[MS_W-1:0];
               CSR_STOP_DELAY:   cfg_stop_delay_ms = csr_wdata[MS_W-1:0];
               CSR_FORCE_ON:     cfg_force_on      = csr_wdata[0];
               CSR_COV_SUPP:     cfg_cov_supported = csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_stall === 1'b0) begin
            taken.op              = req_op;
            taken.now_ms          = req_now_ms;
            taken.blocked         = req_system_blocked;
            taken.fraction        = req_visible_fraction;
            taken.source_present  = req_source_present;
            taken.surface_present = req_surface_present;
            taken.surface_ready   = req_surface_ready;
            taken.frame_requested = req_frame_requested;
            taken.context_ok      = req_context_ok;
            taken.fps             = req_frames_per_second;
            taken.render_ok       = req_render_ok;
            pending_results.push_back(predict_step(taken));
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            seen.start_source     = rsp_start_source;
            seen.stop_source      = rsp_stop_source;
            seen.coverage_changed = rsp_coverage_changed;
            seen.render_issued    = rsp_render_issued;
            seen.frame_presented  = rsp_frame_presented;
            seen.source_running   = rsp_source_running;
            seen.next_deadline_ms = rsp_next_deadline_ms;
            if (pending_results.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: result %0d arrived with no item outstanding", $time,
                           results_seen);
            end else begin
               want = pending_results.pop_front();
               if (seen !== want) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display({"%0t: result %0d mismatch: start/stop/cov/issued/presented/",
                               "running exp %b%b%b%b%b%b got %b%b%b%b%b%b, ",
                               "deadline exp %0d got %0d"},
                              $time, results_seen,
                              want.start_source, want.stop_source, want.coverage_changed,
                              want.render_issued, want.frame_presented, want.source_running,
                              seen.start_source, seen.stop_source, seen.coverage_changed,
                              seen.render_issued, seen.frame_presented, seen.source_running,
                              want.next_deadline_ms, seen.next_deadline_ms);
               end
            end
            results_seen++;
         end
      end
   end

   // Receiver back-pressure: random stall bursts.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_enabled && $urandom_range(7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(15);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("render_gate_and_frame_pacer test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   // A well-formed item: source and surface present, frame wanted, context usable.
   function automatic gate_item_type make_item(input logic [OP_W-1:0]      op,
                                               input logic [TIME_BITS-1:0] at_ms,
                                               input logic [FRAC_W-1:0]    fraction,
                                               input logic                 blocked,
                                               input logic [FPS_W-1:0]     fps);
      gate_item_type it;
      it.op              = op;
      it.now_ms          = at_ms;
      it.blocked         = blocked;
      it.fraction        = fraction;
      it.source_present  = 1'b1;
      it.surface_present = 1'b1;
      it.surface_ready   = 1'b1;
      it.frame_requested = 1'b1;
      it.context_ok      = 1'b1;
      it.fps             = fps;
      it.render_ok       = 1'b1;
      return it;
   endfunction

   // A fraction within two counts of a threshold, to hit both sides of it.
   function automatic logic [FRAC_W-1:0] near_fraction(input logic [FRAC_W-1:0] center);
      int v;
      v = int'(center) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > int'(FRAC_MAX)) v = int'(FRAC_MAX);
      return FRAC_W'(v);
   endfunction

   // Random item on a mostly advancing millisecond clock. Most items are
   // well formed; a minority lack the source or surface, go back in time
   // or jump to an arbitrary time.
   function automatic gate_item_type random_item();
      gate_item_type        it;
      int unsigned          pick;
      logic [OP_W-1:0]      op;
      logic [FRAC_W-1:0]    fraction;
      logic [FPS_W-1:0]     fps;
      pick = $urandom_range(99);
      if (pick < 60)      wall_ms = sat_add(wall_ms, TIME_BITS'($urandom_range(40)));
      else if (pick < 85) wall_ms = sat_add(wall_ms, TIME_BITS'($urandom_range(400)));
      else if (pick < 93) wall_ms = sat_add(wall_ms, TIME_BITS'($urandom_range(3000)));
      else if (pick < 97) wall_ms = wall_ms;
      else if (pick < 99) wall_ms = (wall_ms > TIME_BITS'(500))
                                    ? wall_ms - TIME_BITS'($urandom_range(500)) : '0;
      else                wall_ms = TIME_BITS'({$urandom, $urandom});

      pick = $urandom_range(99);
      if (pick < 42)      op = OP_EVAL;
      else if (pick < 93) op = OP_TICK;
      else if (pick < 97) op = OP_NEW;
      else                op = OP_UNUSED;

      case ($urandom_range(9))
         0:       fraction = '0;
         1:       fraction = FRAC_ONE;
         2, 3:    fraction = near_fraction(cfg_stop_below);
         4, 5:    fraction = near_fraction(cfg_resume_above);
         9:       fraction = FRAC_W'($urandom_range(int'(FRAC_MAX)));
         default: fraction = FRAC_W'($urandom_range(65536));
      endcase

      case ($urandom_range(9))
         0:       fps = '0;
         1:       fps = '1;
         2:       fps = FPS_W'(1);
         default: fps = FPS_W'($urandom_range(1, 255));
      endcase

      it = make_item(op, wall_ms, fraction, $urandom_range(6) == 0, fps);
      it.source_present  = ($urandom_range(24) != 0);
      it.surface_present = ($urandom_range(24) != 0);
      it.surface_ready   = ($urandom_range(9) != 0);
      it.frame_requested = ($urandom_range(6) != 0);
      it.context_ok      = ($urandom_range(9) != 0);
      it.render_ok       = ($urandom_range(4) != 0);
      return it;
   endfunction

   // Sends one item: an optional idle burst, then the item held until the
   // block takes it. Valid stays high on return, so back-to-back items
   // never lower and raise it within one time step.
   task automatic send_item(input gate_item_type it);
      int unsigned gap;
      gap = 0;
      if (send_idling && $urandom_range(4) == 0) gap = $urandom_range(1, 16);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_op                <= it.op;
      req_now_ms            <= it.now_ms;
      req_system_blocked    <= it.blocked;
      req_visible_fraction  <= it.fraction;
      req_source_present    <= it.source_present;
      req_surface_present   <= it.surface_present;
      req_surface_ready     <= it.surface_ready;
      req_frame_requested   <= it.frame_requested;
      req_context_ok        <= it.context_ok;
      req_frames_per_second <= it.fps;
      req_render_ok         <= it.render_ok;
      req_valid             <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // Ends the current burst of items and waits until every result is back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // One register transfer on the configuration channel.
   task automatic write_reg(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Rewrites the whole register file once the block has gone idle.
   task automatic apply_registers(input logic [FRAC_W-1:0] stop_below,
                                  input logic [FRAC_W-1:0] resume_above,
                                  input logic [MS_W-1:0]   poll_ms,
                                  input logic [MS_W-1:0]   delay_ms,
                                  input logic              force_on,
                                  input logic              cov_supported);
      drain_results();
      write_reg(CSR_STOP_BELOW,   CSR_DATA_W'(stop_below));
      write_reg(CSR_RESUME_ABOVE, CSR_DATA_W'(resume_above));
      write_reg(CSR_POLL,         CSR_DATA_W'(poll_ms));
      write_reg(CSR_STOP_DELAY,   CSR_DATA_W'(delay_ms));
      write_reg(CSR_FORCE_ON,     CSR_DATA_W'(force_on));
      write_reg(CSR_COV_SUPP,     CSR_DATA_W'(cov_supported));
   endtask

   // Random traffic; while idling is allowed, both sides re-pick whether
   // they idle every forty items.
   task automatic run_traffic(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (idling_allowed && i % 40 == 0) begin
            send_idling   = ($urandom_range(3) != 0);
            stall_enabled = ($urandom_range(3) != 0);
         end
         send_item(random_item());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Hand-picked walk through the gating and pacing paths at reset settings:
   // poll every 1000 ms, 400 ms grace, covered below 3277, clear at 6554.
   task automatic test_directed_cases();
      gate_item_type it;
      // Without a source or a surface, evaluate and tick leave everything alone.
      it = make_item(OP_EVAL, 100, FRAC_ONE, 1'b0, 8'd30);
      it.source_present = 1'b0;
      send_item(it);
      it = make_item(OP_EVAL, 100, FRAC_ONE, 1'b0, 8'd30);
      it.surface_present = 1'b0;
      send_item(it);
      it = make_item(OP_TICK, 100, '0, 1'b0, 8'd30);
      it.source_present = 1'b0;
      send_item(it);
      // First evaluate samples a fully visible output and starts the source.
      send_item(make_item(OP_EVAL, 100, FRAC_ONE, 1'b0, 8'd30));
      // A rate of zero paces like one frame per second; this render fails.
      it = make_item(OP_TICK, 100, '0, 1'b0, '0);
      it.render_ok = 1'b0;
      send_item(it);
      // A tick before the frame deadline issues nothing.
      send_item(make_item(OP_TICK, 150, '0, 1'b0, 8'd60));
      // Each missing precondition on its own holds the frame back.
      it = make_item(OP_TICK, 1100, '0, 1'b0, '1);
      it.surface_ready = 1'b0;
      send_item(it);
      it.surface_ready   = 1'b1;
      it.frame_requested = 1'b0;
      send_item(it);
      it.frame_requested = 1'b1;
      it.context_ok      = 1'b0;
      send_item(it);
      // All preconditions met at the top rate.
      it.context_ok = 1'b1;
      send_item(it);
      // Fully covered output sets the latch and opens the grace window.
      send_item(make_item(OP_EVAL, 1100, '0, 1'b0, '0));
      // While blocked no sample is taken, even with an oversized fraction.
      send_item(make_item(OP_EVAL, 1200, FRAC_MAX, 1'b1, '0));
      // Grace expired with the block still present: the source stops.
      send_item(make_item(OP_EVAL, 1500, FRAC_MAX, 1'b1, '0));
      // The unused operation only reports the state.
      send_item(make_item(OP_UNUSED, 1600, FRAC_MAX, 1'b0, '1));
      // A visible sample clears the latch and restarts the source.
      send_item(make_item(OP_EVAL, 2100, FRAC_ONE, 1'b0, '0));
      // Blocking again opens a new grace window.
      send_item(make_item(OP_EVAL, 2200, FRAC_ONE, 1'b1, '0));
      // Source detached: the active flag is kept but not reported as running.
      it = make_item(OP_EVAL, 2700, FRAC_ONE, 1'b1, '0);
      it.source_present = 1'b0;
      send_item(it);
      // Unblocked again before the poll is due: the pending stop is dropped.
      send_item(make_item(OP_EVAL, 2300, FRAC_MAX, 1'b0, '0));
      // A new source stops the running one, then finds nothing to stop.
      send_item(make_item(OP_NEW, 2400, '0, 1'b0, '0));
      send_item(make_item(OP_NEW, 2500, '0, 1'b0, '0));
      // At the top of the time range both deadlines saturate.
      send_item(make_item(OP_EVAL, TIME_MAX, FRAC_ONE, 1'b0, '0));
      send_item(make_item(OP_TICK, TIME_MAX, '0, 1'b0, 8'd1));
      // Clearing again brings the deadlines back to time zero.
      send_item(make_item(OP_NEW, '0, '0, 1'b0, '0));
      send_item(make_item(OP_EVAL, '0, FRAC_ONE, 1'b0, '0));
   endtask

   // Runs traffic under a series of register settings, extremes included.
   task automatic test_register_sweep();
      wall_ms = TIME_BITS'(5000);
      // Nothing ever counts as covered; a 1 ms poll and the shortest grace.
      apply_registers('0, '0, MS_W'(1), MS_W'(1), 1'b0, 1'b1);
      run_traffic(55);
      // Covered unless fully visible; zero poll and zero grace.
      apply_registers(FRAC_ONE, FRAC_ONE, '0, '0, 1'b0, 1'b1);
      run_traffic(55);
      // Forced rendering with the slowest poll and longest grace.
      apply_registers(FRAC_W'(20000), FRAC_W'(40000), '1, '1, 1'b1, 1'b1);
      run_traffic(55);
      // Coverage samples ignored; the latch stays where it was left.
      apply_registers(FRAC_W'(40000), FRAC_W'(10000), MS_W'(25), MS_W'(10), 1'b0, 1'b0);
      run_traffic(55);
      // Full-scale thresholds, then a write to an index that maps to nothing.
      apply_registers(FRAC_MAX, FRAC_MAX, MS_W'(300), MS_W'(90), 1'b0, 1'b1);
      write_reg(CSR_UNMAPPED, '1);
      run_traffic(55);
   endtask

   // Long random run with mid-range settings, partly at the top of the time range.
   task automatic test_random_traffic();
      apply_registers(STOP_BELOW_RESET, RESUME_ABOVE_RESET, MS_W'(150), MS_W'(60),
                      1'b0, 1'b1);
      run_traffic(165);
      wall_ms = TIME_MAX - TIME_BITS'(30000);
      run_traffic(165);
   endtask

   // Closing stretch with neither side idling.
   task automatic test_steady_stream();
      idling_allowed = 1'b0;
      send_idling    = 1'b0;
      stall_enabled  = 1'b0;
      wall_ms        = TIME_BITS'(1000);
      run_traffic(100);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_sweep();
      test_random_traffic();
      test_steady_stream();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_results.size() == 0)
         $display("render_gate_and_frame_pacer test passed");
      else
         $display("render_gate_and_frame_pacer test failed");
      $finish;
   end

endmodule
